// File: src/rtbd_pkg.sv
// Shared types and constants for the radio telemetry byte decoder.
// No dependencies; used by every other file of the block but rtbd_ram.
`timescale 1ns / 1ps
`default_nettype none

package rtbd_pkg;

   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 3;
   localparam int READING_W  = 14;
   localparam int MPW_W      = 10;
   localparam int TENTHS_W   = 10;
   localparam int SUM_W      = 16;
   localparam int PROD_W     = 16;
   localparam int DIV_W      = 20;
   localparam int DSR_W      = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam int TEMP_WINDOW_DEFAULT = 50;
   localparam int MPW_RESET           = 100;

   // byte range boundaries
   localparam int B_SQUELCH  = 128;
   localparam int B_ALC      = 130;
   localparam int B_FWD      = 140;
   localparam int B_REFL     = 190;
   localparam int B_OVERTEMP = 215;
   localparam int B_TEMP     = 220;
   localparam int B_TEMP_END = 250;

   localparam int PWR_SCALE    = 20;
   localparam int PWR_DIVISOR  = 99;
   localparam int TENTHS_STEP  = 25;
   localparam int TENTHS_BASE  = 175;
   localparam int FAHR_OFFSET  = 320;

   // 20/99 as one multiply: floor(p * PWR_RECIP / 2^PWR_SHIFT) equals
   // floor(20 * p / 99) for every 16-bit power product p
   localparam int PWR_RECIP = 27114700;
   localparam int PWR_SHIFT = 27;
   localparam int PWR_MUL_W = PWR_SHIFT + READING_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_SIGNAL   = 3'd0,
      KIND_SQUELCH  = 3'd1,
      KIND_ALC      = 3'd2,
      KIND_FWD      = 3'd3,
      KIND_REFL     = 3'd4,
      KIND_OVERTEMP = 3'd5,
      KIND_TEMP     = 3'd6,
      KIND_IGNORED  = 3'd7
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_POWER = 1'b0,
      CSR_SHOW_FAHR = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

// File: src/rtbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rtbd_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 50,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: src/rtbd_div.sv
// Restoring divider, one quotient bit per cycle, for temperature
// averaging. Depends on rtbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtbd_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [rtbd_pkg::DIV_W-1:0] dividend,
   input  wire logic [rtbd_pkg::DSR_W-1:0] divisor,
   output logic                          done,
   output logic      [rtbd_pkg::DIV_W-1:0] quotient
);

   localparam int DW  = rtbd_pkg::DIV_W;
   localparam int SW  = rtbd_pkg::DSR_W;
   localparam int CW  = $clog2(DW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [SW-1:0] dsr_ff, dsr_in;

   logic [SW:0] shifted;
   logic [SW:0] diff;
   logic        ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      diff    = shifted - {1'b0, dsr_ff};
      ge      = (shifted >= {1'b0, dsr_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[SW-1:0] : shifted[SW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: src/radio_telemetry_byte_decoder.sv
// Radio telemetry byte decoder: classifies bytes, scales power, averages temperature.
// Depends on rtbd_pkg, rtbd_ram and rtbd_div.
//
// Usage:
//   Request channel (req_valid/req_ready, req_telemetry_byte) takes one byte per
//   request; each request gives exactly one response on the rsp_ channel.
//   Config writes (csr_we, csr_index, csr_wdata) are registered, no read-back;
//   write them only while the block is idle.
//   One request is in flight at a time. Signal, squelch, ALC, reflected,
//   over-temp and ignored bytes go from acceptance straight to ST_OUT, which
//   raises rsp_valid and frees the input; forward power first passes ST_MUL
//   (multiply) and ST_PREP (a reciprocal multiply for the divide by 99).
//   Temperature bytes pass ST_UPD, ST_PREP and the bit-serial divider in ST_DIV
//   before ST_OUT, the slowest path; no new request is taken until ST_OUT hands
//   the result to the output register, and ST_OUT waits while that is held.
//   Temperature history sits in a RAM of TEMP_WINDOW entries: the old
//   entry is read at acceptance, the new one written back the next cycle.
//   The response sits in an output register; the next request is taken
//   while it waits, and its result holds until the register frees up.
//   Reset (synchronous) empties the history, restores max power to 100 W
//   and selects Celsius; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module radio_telemetry_byte_decoder #(
   parameter int TEMP_WINDOW = rtbd_pkg::TEMP_WINDOW_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [rtbd_pkg::BYTE_W-1:0]       req_telemetry_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [rtbd_pkg::KIND_W-1:0]       rsp_kind,
   output logic      [rtbd_pkg::READING_W-1:0]    rsp_reading,
   output logic                                   rsp_transmit_lock,
   output logic                                   rsp_clear_signal_meter,
   output logic                                   rsp_clear_transmit_meters,
   input  wire logic                              csr_we,
   input  wire logic [rtbd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rtbd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SLOT_W = (TEMP_WINDOW > 1) ? $clog2(TEMP_WINDOW) : 1;
   localparam int FILL_W = $clog2(TEMP_WINDOW + 1);
   localparam int BW     = rtbd_pkg::BYTE_W;
   localparam int RW     = rtbd_pkg::READING_W;
   localparam int TW     = rtbd_pkg::TENTHS_W;
   localparam int SUMW   = rtbd_pkg::SUM_W;
   localparam int DW     = rtbd_pkg::DIV_W;
   localparam int SW     = rtbd_pkg::DSR_W;
   localparam int PW     = rtbd_pkg::PROD_W;
   localparam int MW     = rtbd_pkg::PWR_MUL_W;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_UPD  = 6'b000100,
      ST_PREP = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [BW-1:0]           byte_ff, byte_in;
   rtbd_pkg::kind_type      kind_ff, kind_in;
   logic [RW-1:0]           reading_ff, reading_in;
   logic                    tx_ff, tx_in;
   logic                    clr_tx_ff, clr_tx_in;
   logic [PW-1:0]           prod_ff, prod_in;
   logic [rtbd_pkg::MPW_W-1:0] mpw_ff;
   logic                    fahr_ff;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [SUMW-1:0]         sum_ff, sum_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [rtbd_pkg::KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [RW-1:0]           rsp_reading_ff, rsp_reading_in;
   logic                    rsp_tx_ff, rsp_tx_in;
   logic                    rsp_clr_tx_ff, rsp_clr_tx_in;

   logic                    req_accept;
   logic                    ram_rd_en;
   logic                    ram_wr_en;
   logic [TW-1:0]           ram_rd_data;
   logic [TW-1:0]           tenths;
   logic [TW-1:0]           old_tenths;
   logic                    full;
   logic [BW-1:0]           offs;
   logic [MW-1:0]           pwr_scaled;
   logic                    div_start;
   logic [DW-1:0]           div_dividend;
   logic [SW-1:0]           div_divisor;
   logic                    div_done;
   logic [DW-1:0]           div_quotient;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign full       = (fill_ff == FILL_W'(TEMP_WINDOW));
   // tenths of a degree C for the stored byte
   assign offs       = byte_ff - BW'(rtbd_pkg::B_TEMP);
   assign tenths     = TW'(offs) * TW'(rtbd_pkg::TENTHS_STEP) + TW'(rtbd_pkg::TENTHS_BASE);
   assign old_tenths = full ? ram_rd_data : '0;
   // power product times 20/99, the integer part sits above PWR_SHIFT
   assign pwr_scaled = MW'(prod_ff) * MW'(rtbd_pkg::PWR_RECIP);

   // old slot is read at acceptance so data is ready in ST_UPD
   assign ram_rd_en  = req_accept;
   assign ram_wr_en  = (state_ff == ST_UPD);

   rtbd_ram #(
      .WIDTH (TW),
      .DEPTH (TEMP_WINDOW)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (tenths),
      .rd_en   (ram_rd_en),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   rtbd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in       = state_ff;
      byte_in        = byte_ff;
      kind_in        = kind_ff;
      reading_in     = reading_ff;
      tx_in          = tx_ff;
      clr_tx_in      = clr_tx_ff;
      prod_in        = prod_ff;
      slot_in        = slot_ff;
      fill_in        = fill_ff;
      sum_in         = sum_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_reading_in = rsp_reading_ff;
      rsp_tx_in      = rsp_tx_ff;
      rsp_clr_tx_in  = rsp_clr_tx_ff;
      div_start      = 1'b0;
      div_dividend   = '0;
      div_divisor    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               byte_in    = req_telemetry_byte;
               reading_in = '0;
               tx_in      = 1'b0;
               clr_tx_in  = 1'b0;
               state_in   = ST_OUT;
               priority if (req_telemetry_byte < BW'(rtbd_pkg::B_SQUELCH)) begin
                  kind_in    = rtbd_pkg::KIND_SIGNAL;
                  reading_in = RW'(req_telemetry_byte);
                  clr_tx_in  = 1'b1;
               end else if (req_telemetry_byte < BW'(rtbd_pkg::B_ALC)) begin
                  kind_in    = rtbd_pkg::KIND_SQUELCH;
                  reading_in = RW'(req_telemetry_byte == BW'(rtbd_pkg::B_SQUELCH));
               end else if (req_telemetry_byte < BW'(rtbd_pkg::B_FWD)) begin
                  kind_in    = rtbd_pkg::KIND_ALC;
                  reading_in = RW'(req_telemetry_byte - BW'(rtbd_pkg::B_ALC));
               end else if (req_telemetry_byte < BW'(rtbd_pkg::B_REFL)) begin
                  kind_in    = rtbd_pkg::KIND_FWD;
                  tx_in      = 1'b1;
                  state_in   = ST_MUL;
               end else if (req_telemetry_byte < BW'(rtbd_pkg::B_OVERTEMP)) begin
                  kind_in    = rtbd_pkg::KIND_REFL;
                  reading_in = RW'(req_telemetry_byte - BW'(rtbd_pkg::B_REFL)) << 1;
                  tx_in      = 1'b1;
               end else if (req_telemetry_byte == BW'(rtbd_pkg::B_OVERTEMP)) begin
                  kind_in    = rtbd_pkg::KIND_OVERTEMP;
               end else if (req_telemetry_byte >= BW'(rtbd_pkg::B_TEMP) &&
                            req_telemetry_byte < BW'(rtbd_pkg::B_TEMP_END)) begin
                  kind_in    = rtbd_pkg::KIND_TEMP;
                  state_in   = ST_UPD;
               end else begin
                  kind_in    = rtbd_pkg::KIND_IGNORED;
               end
            end
         end
         ST_MUL: begin
            prod_in  = PW'(mpw_ff) * PW'(byte_ff - BW'(rtbd_pkg::B_FWD));
            state_in = ST_PREP;
         end
         ST_UPD: begin
            // drop the oldest entry only once the ring is full
            sum_in  = sum_ff - SUMW'(old_tenths) + SUMW'(tenths);
            slot_in = (slot_ff == SLOT_W'(TEMP_WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            if (!full) begin
               fill_in = fill_ff + 1'b1;
            end
            state_in = ST_PREP;
         end
         ST_PREP: begin
            if (kind_ff == rtbd_pkg::KIND_FWD) begin
               reading_in = pwr_scaled[rtbd_pkg::PWR_SHIFT +: RW];
               state_in   = ST_OUT;
            end else begin
               div_start = 1'b1;
               if (fahr_ff) begin
                  // round(sum*9 / (5*fill))
                  div_dividend = DW'(sum_ff) * DW'(18) + DW'(fill_ff) * DW'(5);
                  div_divisor  = SW'(fill_ff) * SW'(10);
               end else begin
                  div_dividend = (DW'(sum_ff) << 1) + DW'(fill_ff);
                  div_divisor  = SW'(fill_ff) << 1;
               end
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               reading_in = div_quotient[RW-1:0];
               if (kind_ff == rtbd_pkg::KIND_TEMP && fahr_ff) begin
                  reading_in = div_quotient[RW-1:0] + RW'(rtbd_pkg::FAHR_OFFSET);
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = kind_ff;
               rsp_reading_in = reading_ff;
               rsp_tx_in      = tx_ff;
               rsp_clr_tx_in  = clr_tx_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mpw_ff  <= rtbd_pkg::MPW_W'(rtbd_pkg::MPW_RESET);
         fahr_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            rtbd_pkg::CSR_MAX_POWER: mpw_ff  <= csr_wdata[rtbd_pkg::MPW_W-1:0];
            rtbd_pkg::CSR_SHOW_FAHR: fahr_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      byte_ff        <= byte_in;
      kind_ff        <= kind_in;
      reading_ff     <= reading_in;
      tx_ff          <= tx_in;
      clr_tx_ff      <= clr_tx_in;
      prod_ff        <= prod_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_reading_ff <= rsp_reading_in;
      rsp_tx_ff      <= rsp_tx_in;
      rsp_clr_tx_ff  <= rsp_clr_tx_in;
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_kind                  = rsp_kind_ff;
   assign rsp_reading               = rsp_reading_ff;
   assign rsp_transmit_lock         = rsp_tx_ff;
   assign rsp_clear_signal_meter    = rsp_tx_ff;
   assign rsp_clear_transmit_meters = rsp_clr_tx_ff;

endmodule

`default_nettype wire

// File: src/rtbd_checker.sv
// Port-level checks for the telemetry decoder, bound to the top level.
// Depends on rtbd_pkg and radio_telemetry_byte_decoder.
`timescale 1ns / 1ps
`default_nettype none

module rtbd_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic [rtbd_pkg::BYTE_W-1:0]       req_telemetry_byte,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [rtbd_pkg::KIND_W-1:0]       rsp_kind,
   input wire logic [rtbd_pkg::READING_W-1:0]    rsp_reading,
   input wire logic                              rsp_transmit_lock,
   input wire logic                              rsp_clear_signal_meter,
   input wire logic                              rsp_clear_transmit_meters,
   input wire logic                              csr_we,
   input wire logic [rtbd_pkg::CSR_IDX_W-1:0]    csr_index,
   input wire logic [rtbd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_reading))
      else $error("response changed while stalled");

   // one request in flight: ready drops right after acceptance
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   // flags follow the kind
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_transmit_lock == rsp_clear_signal_meter) &&
                    (rsp_transmit_lock == (rsp_kind == rtbd_pkg::KIND_FWD ||
                                           rsp_kind == rtbd_pkg::KIND_REFL)) &&
                    (rsp_clear_transmit_meters == (rsp_kind == rtbd_pkg::KIND_SIGNAL)))
      else $error("flags do not match kind");

   a_zero_reading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == rtbd_pkg::KIND_OVERTEMP ||
                    rsp_kind == rtbd_pkg::KIND_IGNORED) |-> rsp_reading == '0)
      else $error("nonzero reading for alarm or ignored byte");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind radio_telemetry_byte_decoder rtbd_checker u_rtbd_checker (.*);

`default_nettype wire

// File: sim/tb_radio_telemetry_byte_decoder.sv
// Testbench for radio_telemetry_byte_decoder: directed and random requests vs a local decoder.
// Depends on rtbd_pkg and the block's RTL under src.
// Self-contained: no files or arguments are read.
`timescale 1ns / 1ps

module tb_radio_telemetry_byte_decoder;

   localparam int CYCLE_LIMIT = 400_000;
   localparam int SETTLE      = 40;
   localparam int WINDOW      = rtbd_pkg::TEMP_WINDOW_DEFAULT;
   localparam int BYTE_W      = rtbd_pkg::BYTE_W;
   localparam int KIND_W      = rtbd_pkg::KIND_W;
   localparam int READ_W      = rtbd_pkg::READING_W;
   localparam int TEN_W       = rtbd_pkg::TENTHS_W;
   localparam int MPW_W       = rtbd_pkg::MPW_W;
   localparam int CIDX_W      = rtbd_pkg::CSR_IDX_W;
   localparam int CDATA_W     = rtbd_pkg::CSR_DATA_W;

   typedef struct {
      rtbd_pkg::kind_type      kind;
      logic [READ_W-1:0]       reading;
      logic                    transmit_lock;
      logic                    clear_signal_meter;
      logic                    clear_transmit_meters;
   } readout_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [BYTE_W-1:0]       req_telemetry_byte = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [KIND_W-1:0]       rsp_kind;
   logic [READ_W-1:0]       rsp_reading;
   logic                    rsp_transmit_lock;
   logic                    rsp_clear_signal_meter;
   logic                    rsp_clear_transmit_meters;
   logic                    csr_we = 1'b0;
   logic [CIDX_W-1:0]       csr_index = '0;
   logic [CDATA_W-1:0]      csr_wdata = '0;

   radio_telemetry_byte_decoder dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_telemetry_byte        (req_telemetry_byte),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_kind                  (rsp_kind),
      .rsp_reading               (rsp_reading),
      .rsp_transmit_lock         (rsp_transmit_lock),
      .rsp_clear_signal_meter    (rsp_clear_signal_meter),
      .rsp_clear_transmit_meters (rsp_clear_transmit_meters),
      .csr_we                    (csr_we),
      .csr_index                 (csr_index),
      .csr_wdata                 (csr_wdata)
   );

   always #6 clock = ~clock;

   // local copy of the decoder's registers and temperature ring
   logic [MPW_W-1:0]     max_power;
   logic                 fahrenheit;
   logic [TEN_W-1:0]     temp_ring [WINDOW];
   int unsigned          ring_slot;
   int unsigned          ring_fill;
   int unsigned          ring_sum;

   logic [BYTE_W-1:0]    pending_bytes [$];
   readout_type          expected_readouts [$];
   int                   error_count = 0;
   int unsigned          cycle_count = 0;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // random stalls, with a stall-free stretch at the start of every period
   function automatic bit take_break();
      return (cycle_count % 8000 >= 2000) && ($urandom_range(0, 99) < 14);
   endfunction

   function automatic int unsigned average_temp();
      if (fahrenheit)
         return (ring_sum * 18 + 5 * ring_fill) / (10 * ring_fill) + rtbd_pkg::FAHR_OFFSET;
      return (ring_sum * 2 + ring_fill) / (2 * ring_fill);
   endfunction

   // classify one byte and advance the temperature ring
   function automatic readout_type decode_byte(logic [BYTE_W-1:0] raw);
      readout_type r;
      int unsigned b;
      int unsigned tenths;
      b = raw;
      r.kind = rtbd_pkg::KIND_IGNORED;
      r.reading = '0;
      r.transmit_lock = (b >= rtbd_pkg::B_FWD && b < rtbd_pkg::B_OVERTEMP);
      r.clear_signal_meter = r.transmit_lock;
      r.clear_transmit_meters = (b < rtbd_pkg::B_SQUELCH);
      if (b < rtbd_pkg::B_SQUELCH) begin
         r.kind = rtbd_pkg::KIND_SIGNAL;
         r.reading = READ_W'(b);
      end else if (b < rtbd_pkg::B_ALC) begin
         r.kind = rtbd_pkg::KIND_SQUELCH;
         r.reading = READ_W'(b == rtbd_pkg::B_SQUELCH);
      end else if (b < rtbd_pkg::B_FWD) begin
         r.kind = rtbd_pkg::KIND_ALC;
         r.reading = READ_W'(b - rtbd_pkg::B_ALC);
      end else if (b < rtbd_pkg::B_REFL) begin
         r.kind = rtbd_pkg::KIND_FWD;
         r.reading = READ_W'((int'(max_power) * rtbd_pkg::PWR_SCALE * (b - rtbd_pkg::B_FWD))
                             / rtbd_pkg::PWR_DIVISOR);
      end else if (b < rtbd_pkg::B_OVERTEMP) begin
         r.kind = rtbd_pkg::KIND_REFL;
         r.reading = READ_W'(2 * (b - rtbd_pkg::B_REFL));
      end else if (b == rtbd_pkg::B_OVERTEMP) begin
         r.kind = rtbd_pkg::KIND_OVERTEMP;
      end else if (b >= rtbd_pkg::B_TEMP && b < rtbd_pkg::B_TEMP_END) begin
         r.kind = rtbd_pkg::KIND_TEMP;
         tenths = (b - rtbd_pkg::B_TEMP) * rtbd_pkg::TENTHS_STEP + rtbd_pkg::TENTHS_BASE;
         // oldest entry drops out only once the ring is full
         if (ring_fill >= WINDOW) ring_sum = ring_sum - temp_ring[ring_slot];
         temp_ring[ring_slot] = TEN_W'(tenths);
         ring_sum = (ring_sum + tenths) & 16'hFFFF;
         ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;
         if (ring_fill < WINDOW) ring_fill++;
         r.reading = READ_W'(average_temp());
      end
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_readouts.push_back(decode_byte(req_telemetry_byte));
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() > 0 && !take_break()) begin
               req_valid <= 1'b1;
               req_telemetry_byte <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      readout_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readouts.size() == 0) begin
            $error("unexpected response: kind %0d reading %0d", rsp_kind, rsp_reading);
            error_count++;
         end else begin
            e = expected_readouts.pop_front();
            if (rsp_kind !== e.kind) begin
               $error("kind: expected %0d, got %0d", e.kind, rsp_kind);
               error_count++;
            end
            if (rsp_reading !== e.reading) begin
               $error("reading: expected %0d, got %0d", e.reading, rsp_reading);
               error_count++;
            end
            if (rsp_transmit_lock !== e.transmit_lock) begin
               $error("transmit_lock: expected %0d, got %0d",
                      e.transmit_lock, rsp_transmit_lock);
               error_count++;
            end
            if (rsp_clear_signal_meter !== e.clear_signal_meter) begin
               $error("clear_signal_meter: expected %0d, got %0d",
                      e.clear_signal_meter, rsp_clear_signal_meter);
               error_count++;
            end
            if (rsp_clear_transmit_meters !== e.clear_transmit_meters) begin
               $error("clear_transmit_meters: expected %0d, got %0d",
                      e.clear_transmit_meters, rsp_clear_transmit_meters);
               error_count++;
            end
         end
      end
      rsp_ready <= !take_break();
   end

   task automatic wait_drained();
      while (pending_bytes.size() > 0 || req_valid || expected_readouts.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(rtbd_pkg::csr_index_type idx, logic [CDATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      unique case (idx)
         rtbd_pkg::CSR_MAX_POWER: max_power = value[MPW_W-1:0];
         rtbd_pkg::CSR_SHOW_FAHR: fahrenheit = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly temperature and forward power, which carry state and arithmetic
   function automatic logic [BYTE_W-1:0] random_telemetry();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)
         return BYTE_W'($urandom_range(rtbd_pkg::B_TEMP, rtbd_pkg::B_TEMP_END - 1));
      if (pick < 55)
         return BYTE_W'($urandom_range(rtbd_pkg::B_FWD, rtbd_pkg::B_REFL - 1));
      if (pick < 62)
         return BYTE_W'($urandom_range(rtbd_pkg::B_SQUELCH, rtbd_pkg::B_FWD - 1));
      if (pick < 68)
         return BYTE_W'($urandom_range(rtbd_pkg::B_OVERTEMP, rtbd_pkg::B_TEMP - 1));
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   logic [CDATA_W-1:0]    power_plan [6];
   logic [CDATA_W-1:0]    scale_plan [6];
   logic [BYTE_W-1:0]     directed [$];

   initial begin
      max_power = MPW_W'(rtbd_pkg::MPW_RESET);
      fahrenheit = 1'b0;
      ring_slot = 0;
      ring_fill = 0;
      ring_sum = 0;

      power_plan = '{10'd1023, 10'd0, 10'd1, 10'd0, 10'd512, 10'd0};
      power_plan[3] = CDATA_W'($urandom_range(0, 1023));
      power_plan[5] = CDATA_W'($urandom_range(0, 1023));
      // upper data bits of the unit register are masked off
      scale_plan = '{10'd1, 10'd0, 10'd1, 10'h3FE, 10'h3FF, 10'd0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // range edges, squelch open and closed, bit patterns, temperature extremes
      directed = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd130, 8'd139, 8'd140, 8'd141,
                   8'd189, 8'd190, 8'd214, 8'd215, 8'd216, 8'd219, 8'd220, 8'd249,
                   8'd250, 8'd255, 8'h55, 8'hAA, 8'd249, 8'd220};
      foreach (directed[i]) pending_bytes.push_back(directed[i]);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         write_reg(rtbd_pkg::CSR_MAX_POWER, power_plan[p]);
         write_reg(rtbd_pkg::CSR_SHOW_FAHR, scale_plan[p]);
         repeat (165) pending_bytes.push_back(random_telemetry());
         wait_drained();
      end

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
